@@ hw/rtl/frame_sequence_queue_assert.svh @@
// Assertion macros used by the frame sequence queue top-level module.
`ifndef FRAME_SEQUENCE_QUEUE_ASSERT_SVH
`define FRAME_SEQUENCE_QUEUE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FSQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FSQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/fsq_pkg.sv @@
package fsq_pkg;

   // Number of pending sequences held in the cell chain.
   localparam int QUEUE_DEPTH = 4;
   // Width of the fill count, which must hold QUEUE_DEPTH itself.
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Request kinds.
   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_ADD  = 2'd1;
   localparam logic [1:0] MODE_ICON = 2'd2;

   // One sequence: start frame, length, repeat flag and variant.
   typedef struct packed {
      logic       variant;
      logic       repeat_flag;
      logic [7:0] length;
      logic [7:0] start;
   } entry_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic      shift;
      logic      load;
      entry_type data;
   } cell_ctl_type;

   // One response item.
   typedef struct packed {
      logic [8:0] icon_index;
      logic       icon_variant;
      logic       show;
      logic       dropped;
   } rsp_type;

endpackage

@@ hw/rtl/fsq_cell.sv @@
module fsq_cell import fsq_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    next_entry,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // A load takes the new sequence; a pop takes the neighbor's entry.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = ctl.data;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ hw/rtl/fsq_out_buf.sv @@
module fsq_out_buf import fsq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_stall
);

   logic    out_valid_ff;
   logic    out_valid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    pop;

   assign pop = out_valid_ff && !out_stall;

   // Output register with a skid slot behind it. The upstream side stalls
   // only while the skid slot is occupied, so it never pushes then.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_in = push;
         out_data_in  = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ hw/rtl/frame_sequence_queue.sv @@
// Channel    | Handshake           | Payload
// -----------+---------------------+---------------------------------------------
// request    | req_valid/req_stall | mode, start_frame, frame_count, repeat, flush
// response   | rsp_valid/rsp_stall | icon_index, icon_variant, show, dropped
//
// One request is taken every cycle while req_stall is low; its response goes out from
// the output register. The whole sequencer update, including a queue push or
// pop through the cell chain, completes in the accepting cycle.
// Reset is synchronous and active high; no clearing pass is needed.
// A two-entry output buffer lets a request be taken while one response waits;
// req_stall rises only once both entries hold unread responses.
module frame_sequence_queue import fsq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_start_frame,
   input  logic [7:0] req_frame_count,
   input  logic       req_repeat_req,
   input  logic       req_flush_queue,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [8:0] rsp_icon_index,
   output logic       rsp_icon_variant,
   output logic       rsp_show,
   output logic       rsp_dropped
);

`include "frame_sequence_queue_assert.svh"

   localparam logic [CNT_W-1:0] CountFull = CNT_W'(QUEUE_DEPTH);

   logic             running_ff;
   logic             running_in;
   logic [7:0]       position_ff;
   logic [7:0]       position_in;
   entry_type        cur_ff;
   entry_type        cur_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic             buf_full;
   logic             accept;
   logic             res_valid;
   rsp_type          res_data;
   rsp_type          buf_data;
   logic             shift;
   logic             wr_en;
   logic [CNT_W-1:0] wr_slot;
   entry_type        wr_data;
   entry_type        head;
   logic [7:0]       pos_sel;
   entry_type        cur_sel;
   logic [7:0]       len_eff;

   cell_ctl_type     cell_ctl   [QUEUE_DEPTH];
   entry_type        cell_entry [QUEUE_DEPTH];

   assign accept  = req_valid && !buf_full;
   assign head    = cell_entry[0];
   assign len_eff = (req_frame_count == 8'd0) ? 8'd1 : req_frame_count;

   // Sequencer: decides the new current sequence, the queue operation and the
   // response for the accepted request.
   always_comb begin
      running_in  = running_ff;
      position_in = position_ff;
      cur_in      = cur_ff;
      count_in    = count_ff;
      res_valid   = 1'b0;
      res_data    = '0;
      shift       = 1'b0;
      wr_en       = 1'b0;
      wr_slot     = count_ff;
      wr_data     = '0;
      pos_sel     = position_ff;
      cur_sel     = cur_ff;
      if (accept) begin
         case (req_mode)
            MODE_TICK: begin
               if (running_ff) begin
                  if (position_ff >= cur_ff.length) begin
                     pos_sel = 8'd0;
                     if (count_ff != '0) begin
                        // End of sequence: take the next one from the queue.
                        cur_sel  = head;
                        shift    = 1'b1;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  if ((position_ff >= cur_ff.length) && (count_ff == '0) &&
                      !cur_ff.repeat_flag) begin
                     running_in = 1'b0;
                  end else begin
                     cur_in                = cur_sel;
                     position_in           = pos_sel + 8'd1;
                     res_valid             = 1'b1;
                     res_data.icon_index   = {1'b0, cur_sel.start} + {1'b0, pos_sel};
                     res_data.icon_variant = cur_sel.variant;
                     res_data.show         = 1'b1;
                  end
               end
            end
            MODE_ADD: begin
               res_valid = 1'b1;
               if (running_ff) begin
                  wr_slot             = req_flush_queue ? '0 : count_ff;
                  wr_data.start       = req_start_frame;
                  wr_data.length      = len_eff;
                  wr_data.repeat_flag = req_repeat_req;
                  wr_data.variant     = 1'b0;
                  if (wr_slot == CountFull) begin
                     res_data.dropped = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = wr_slot + CNT_W'(1);
                  end
               end else begin
                  // Idle: start the sequence at once.
                  cur_in.start        = req_start_frame;
                  cur_in.length       = len_eff;
                  cur_in.repeat_flag  = req_repeat_req;
                  cur_in.variant      = 1'b0;
                  position_in         = 8'd0;
                  count_in            = '0;
                  running_in          = 1'b1;
                  res_data.icon_index = {1'b0, req_start_frame};
                  res_data.show       = 1'b1;
               end
            end
            MODE_ICON: begin
               res_valid = 1'b1;
               if (running_ff) begin
                  // Replace the queue with a single static frame.
                  wr_en               = 1'b1;
                  wr_slot             = '0;
                  wr_data.start       = req_start_frame;
                  wr_data.length      = 8'd1;
                  wr_data.repeat_flag = 1'b0;
                  wr_data.variant     = 1'b1;
                  count_in            = CNT_W'(1);
               end else begin
                  res_data.icon_index   = {1'b0, req_start_frame};
                  res_data.icon_variant = 1'b1;
                  res_data.show         = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         position_ff <= 8'd0;
         cur_ff      <= '{variant: 1'b0, repeat_flag: 1'b0, length: 8'd1, start: 8'd0};
         count_ff    <= '0;
      end else begin
         running_ff  <= running_in;
         position_ff <= position_in;
         cur_ff      <= cur_in;
         count_ff    <= count_in;
      end
   end

   // Pending queue: a chain of cells, each shifting toward the head on a pop.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      always_comb begin
         cell_ctl[i].shift = shift;
         cell_ctl[i].load  = wr_en && (wr_slot == CNT_W'(i));
         cell_ctl[i].data  = wr_data;
      end

      fsq_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .next_entry (cell_entry[(i + 1 < QUEUE_DEPTH) ? i + 1 : i]),
         .entry      (cell_entry[i])
      );
   end

   // Response buffer.
   fsq_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (buf_data),
      .out_stall (rsp_stall)
   );

   assign req_stall        = buf_full;
   assign rsp_icon_index   = buf_data.icon_index;
   assign rsp_icon_variant = buf_data.icon_variant;
   assign rsp_show         = buf_data.show;
   assign rsp_dropped      = buf_data.dropped;

   // The queue never holds more than its depth.
   `FSQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CountFull, "pending count overflow")
   // While running, the position never passes the length of the sequence.
   `FSQ_ASSERT_NOW(a_position_bound, running_ff, position_ff <= cur_ff.length,
      "position beyond sequence length")
   // The request side stalls only when a response is waiting and was stalled.
   `FSQ_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && $past(rsp_stall),
      "request stall without a stalled response")
   // A response pushed while the output is stalled lands in the skid slot.
   `FSQ_ASSERT_NEXT(a_skid_fill, res_valid && rsp_valid && rsp_stall, req_stall,
      "response lost while output stalled")

endmodule

@@ tb/frame_sequence_queue_test.sv @@
module frame_sequence_queue_test;
   import fsq_pkg::*;

   // The fourth request kind is unused and must be ignored by the block.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // Cycles without any accepted request or response before the run is abandoned.
   localparam int STALL_LIMIT = 3000;
   // Random requests per idling phase.
   localparam int PHASE_ITEMS = 168;

   // Tracks the sequencer state and the frames it is expected to show.
   class frame_scoreboard;
      logic       running;
      logic [7:0] position;
      logic [7:0] cur_start;
      logic [7:0] cur_length;
      logic       cur_repeat;
      logic       cur_variant;
      entry_type  pending[QUEUE_DEPTH];
      int         pending_count;
      rsp_type    expected_frames[$];
      int         failures;

      function new();
         running = 1'b0;
         position = 8'd0;
         cur_start = 8'd0;
         cur_length = 8'd1;
         cur_repeat = 1'b0;
         cur_variant = 1'b0;
         pending_count = 0;
         failures = 0;
      endfunction

      // Applies one accepted request to the state and queues its response, if any.
      function void note_request(logic [1:0] mode, logic [7:0] start, logic [7:0] count,
                                 logic rep, logic flush);
         logic [7:0] len;
         rsp_type    rsp;
         entry_type  slot;
         bit         has_rsp;
         len = (count == 8'd0) ? 8'd1 : count;
         rsp = '0;
         has_rsp = 1'b0;
         case (mode)
            MODE_TICK: begin
               if (running) begin
                  if (position >= cur_length) begin
                     if (pending_count == 0) begin
                        // Loop when repeating, otherwise the sequence stops.
                        if (cur_repeat) position = 8'd0;
                        else running = 1'b0;
                     end else begin
                        // Pop the head of the queue and shift the rest down.
                        cur_start = pending[0].start;
                        cur_length = pending[0].length;
                        cur_repeat = pending[0].repeat_flag;
                        cur_variant = pending[0].variant;
                        position = 8'd0;
                        for (int i = 1; i < pending_count; i++) pending[i - 1] = pending[i];
                        pending_count--;
                     end
                  end
                  if (running) begin
                     rsp.icon_index = {1'b0, cur_start} + {1'b0, position};
                     rsp.icon_variant = cur_variant;
                     rsp.show = 1'b1;
                     position = position + 8'd1;
                     has_rsp = 1'b1;
                  end
               end
            end
            MODE_ADD: begin
               has_rsp = 1'b1;
               if (running) begin
                  if (flush) pending_count = 0;
                  if (pending_count >= QUEUE_DEPTH) begin
                     rsp.dropped = 1'b1;
                  end else begin
                     slot.start = start;
                     slot.length = len;
                     slot.repeat_flag = rep;
                     slot.variant = 1'b0;
                     pending[pending_count] = slot;
                     pending_count++;
                  end
               end else begin
                  // An idle sequencer starts the new sequence at once.
                  cur_start = start;
                  cur_length = len;
                  cur_repeat = rep;
                  cur_variant = 1'b0;
                  position = 8'd0;
                  pending_count = 0;
                  running = 1'b1;
                  rsp.icon_index = {1'b0, start};
                  rsp.show = 1'b1;
               end
            end
            MODE_ICON: begin
               has_rsp = 1'b1;
               if (running) begin
                  // The icon replaces the whole queue with one static frame.
                  slot.start = start;
                  slot.length = 8'd1;
                  slot.repeat_flag = 1'b0;
                  slot.variant = 1'b1;
                  pending[0] = slot;
                  pending_count = 1;
               end else begin
                  rsp.icon_index = {1'b0, start};
                  rsp.icon_variant = 1'b1;
                  rsp.show = 1'b1;
               end
            end
            default: ;
         endcase
         if (has_rsp) expected_frames.push_back(rsp);
      endfunction

      // Compares one accepted response with the oldest expected one.
      function void check_response(logic [8:0] index, logic variant, logic show,
                                   logic dropped);
         rsp_type want;
         if (expected_frames.size() == 0) begin
            $error("unexpected response: icon_index %0d", index);
            failures++;
            return;
         end
         want = expected_frames.pop_front();
         if (index !== want.icon_index) begin
            $error("icon_index: expected %0d, actual %0d", want.icon_index, index);
            failures++;
         end
         if (variant !== want.icon_variant) begin
            $error("icon_variant: expected %0d, actual %0d", want.icon_variant, variant);
            failures++;
         end
         if (show !== want.show) begin
            $error("show: expected %0d, actual %0d", want.show, show);
            failures++;
         end
         if (dropped !== want.dropped) begin
            $error("dropped: expected %0d, actual %0d", want.dropped, dropped);
            failures++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_mode = MODE_TICK;
   logic [7:0] req_start_frame = 8'd0;
   logic [7:0] req_frame_count = 8'd1;
   logic       req_repeat_req = 1'b0;
   logic       req_flush_queue = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [8:0] rsp_icon_index;
   logic       rsp_icon_variant;
   logic       rsp_show;
   logic       rsp_dropped;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;

   frame_scoreboard sb;

   frame_sequence_queue dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_start_frame  (req_start_frame),
      .req_frame_count  (req_frame_count),
      .req_repeat_req   (req_repeat_req),
      .req_flush_queue  (req_flush_queue),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_icon_index   (rsp_icon_index),
      .rsp_icon_variant (rsp_icon_variant),
      .rsp_show         (rsp_show),
      .rsp_dropped      (rsp_dropped)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predict from every accepted request.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_request(req_mode, req_start_frame, req_frame_count, req_repeat_req,
                         req_flush_queue);
      end
   end

   // Check every accepted response, then choose the next stall value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_icon_index, rsp_icon_variant, rsp_show, rsp_dropped);
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Abandon the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request, with random idle cycles first, and waits until it is taken.
   task automatic send_request(logic [1:0] mode, logic [7:0] start, logic [7:0] count,
                               logic rep, logic flush);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_start_frame <= start;
      req_frame_count <= count;
      req_repeat_req <= rep;
      req_flush_queue <= flush;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Random traffic, mostly ticks and adds with short sequences.
   task automatic random_phase(int items);
      int         sent;
      int         pick;
      logic [1:0] mode;
      logic [7:0] count;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 52) mode = MODE_TICK;
         else if (pick < 84) mode = MODE_ADD;
         else if (pick < 96) mode = MODE_ICON;
         else mode = MODE_UNUSED;
         pick = $urandom_range(99);
         if (pick < 70) count = 8'($urandom_range(5));
         else if (pick < 97) count = 8'($urandom_range(20, 1));
         else count = 8'($urandom);
         send_request(mode, 8'($urandom), count, ($urandom_range(99) < 40),
                      ($urandom_range(99) < 15));
         if (mode != MODE_UNUSED) sent++;
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed requests with light request idling and frequent response stalls.
      send_idle_pct = 12;
      recv_idle_pct = 53;
      send_request(MODE_TICK, 8'd0, 8'd1, 1'b0, 1'b0);      // tick while idle
      send_request(MODE_UNUSED, 8'hff, 8'hff, 1'b1, 1'b1);  // ignored kind
      send_request(MODE_ICON, 8'hff, 8'd0, 1'b0, 1'b0);     // icon while idle
      send_request(MODE_ADD, 8'hff, 8'd0, 1'b0, 1'b0);      // zero length start
      send_request(MODE_TICK, 8'd0, 8'd0, 1'b0, 1'b0);
      send_request(MODE_TICK, 8'd0, 8'd0, 1'b0, 1'b0);      // stops at end
      send_request(MODE_ADD, 8'hff, 8'd3, 1'b1, 1'b1);      // flush while idle
      repeat (4) send_request(MODE_TICK, 8'd0, 8'd0, 1'b0, 1'b0);  // wraps and loops
      send_request(MODE_ADD, 8'd0, 8'd2, 1'b0, 1'b0);
      send_request(MODE_ADD, 8'd1, 8'd1, 1'b1, 1'b0);
      send_request(MODE_ADD, 8'd2, 8'd0, 1'b0, 1'b0);
      send_request(MODE_ADD, 8'd3, 8'd255, 1'b0, 1'b0);     // queue now full
      send_request(MODE_ADD, 8'd4, 8'd4, 1'b0, 1'b0);       // dropped
      send_request(MODE_ADD, 8'd7, 8'd255, 1'b1, 1'b1);     // flush keeps it
      send_request(MODE_ICON, 8'haa, 8'd9, 1'b1, 1'b1);     // icon replaces queue
      repeat (5) send_request(MODE_TICK, 8'd0, 8'd0, 1'b0, 1'b0);

      // Random traffic across the three idling phases.
      random_phase(PHASE_ITEMS);
      send_idle_pct = 53;
      recv_idle_pct = 12;
      random_phase(PHASE_ITEMS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(PHASE_ITEMS);
      req_valid <= 1'b0;

      // Drain, then leave room for any stray response.
      while (sb.expected_frames.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (sb.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
